// File: rtl/sts_pkg.sv
package sts_pkg;

  localparam int unsigned POSITION_BITS_DEF = 16;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_QUOTE      = 8'h22;
  localparam logic [7:0] CH_NEWLINE    = 8'h0A;
  localparam logic [7:0] CH_SLASH      = 8'h2F;
  localparam logic [7:0] CH_STAR       = 8'h2A;
  localparam logic [7:0] CH_EQUAL      = 8'h3D;
  localparam logic [7:0] CH_AMP        = 8'h26;
  localparam logic [7:0] CH_BAR        = 8'h7C;

  typedef enum logic [2:0] {
    KIND_NUM   = 3'd0,
    KIND_IDENT = 3'd1,
    KIND_STR   = 3'd2,
    KIND_OP    = 3'd3,
    KIND_SYM   = 3'd4,
    KIND_UNK   = 3'd5,
    KIND_END   = 3'd6
  } kind_t;

  typedef enum logic [9:0] {
    M_IDLE     = 10'b00_0000_0001,
    M_NUM      = 10'b00_0000_0010,
    M_IDENT    = 10'b00_0000_0100,
    M_STR_OPEN = 10'b00_0000_1000,
    M_STR      = 10'b00_0001_0000,
    M_PAIR     = 10'b00_0010_0000,
    M_SLASH    = 10'b00_0100_0000,
    M_LINE     = 10'b00_1000_0000,
    M_BLOCK    = 10'b01_0000_0000,
    M_BSTAR    = 10'b10_0000_0000
  } mode_t;

  typedef struct packed {
    logic [7:0] ch;
    kind_t      kind;
    logic       first;
    logic       valid;
  } hold_t;

  typedef struct packed {
    logic [7:0] src_byte;
    logic       end_of_source;
  } in_t;

  typedef struct packed {
    logic [7:0]  tok_byte;
    kind_t       tok_kind;
    logic        tok_first;
    logic        tok_last;
    logic [15:0] tok_line;
    logic [15:0] tok_column;
  } out_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_ident_start(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) ||
           (c == CH_UNDERSCORE);
  endfunction

  function automatic logic is_ident_more(input logic [7:0] c);
    return is_ident_start(c) || is_digit(c);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  // Bytes that may pair with a following byte.
  function automatic logic is_pair_lead(input logic [7:0] c);
    return (c == "<") || (c == ">") || (c == "!") || (c == CH_AMP) || (c == CH_BAR);
  endfunction

  // Kind of a byte that forms a token on its own.
  function automatic kind_t single_kind(input logic [7:0] c);
    if ((c == "+") || (c == "-") || (c == CH_STAR) || (c == CH_EQUAL)) begin
      return KIND_OP;
    end
    if ((c == "(") || (c == ")") || (c == "{") || (c == "}") || (c == ";") ||
        (c == ",")) begin
      return KIND_SYM;
    end
    return KIND_UNK;
  endfunction

endpackage

// File: rtl/sts_step.sv
module sts_step #(
  parameter int unsigned POSITION_BITS = sts_pkg::POSITION_BITS_DEF
) (
  input  sts_pkg::in_t               item,
  input  sts_pkg::mode_t             mode,
  input  sts_pkg::hold_t             held,
  input  logic [POSITION_BITS-1:0]   line,
  input  logic [POSITION_BITS-1:0]   column,
  input  logic [POSITION_BITS-1:0]   start_line,
  input  logic [POSITION_BITS-1:0]   start_column,
  output sts_pkg::mode_t             mode_next,
  output sts_pkg::hold_t             held_next,
  output logic [POSITION_BITS-1:0]   line_next,
  output logic [POSITION_BITS-1:0]   column_next,
  output logic [POSITION_BITS-1:0]   start_line_next,
  output logic [POSITION_BITS-1:0]   start_column_next,
  output logic [1:0]                 res_count,
  output sts_pkg::out_t              res0,
  output sts_pkg::out_t              res1
);

  localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

  function automatic sts_pkg::out_t mk(input logic [7:0] b, input sts_pkg::kind_t k,
                                       input logic f, input logic l,
                                       input logic [POSITION_BITS-1:0] pl,
                                       input logic [POSITION_BITS-1:0] pc);
    sts_pkg::out_t r;
    r.tok_byte   = b;
    r.tok_kind   = k;
    r.tok_first  = f;
    r.tok_last   = l;
    r.tok_line   = 16'(pl);
    r.tok_column = 16'(pc);
    return r;
  endfunction

  logic [7:0]    c;
  logic [7:0]    want;
  logic          do_begin;
  logic [1:0]    n;
  sts_pkg::out_t r [2];

  assign c = item.src_byte;
  assign want = ((held.ch == sts_pkg::CH_AMP) || (held.ch == sts_pkg::CH_BAR)) ?
                held.ch : sts_pkg::CH_EQUAL;

  always_comb begin
    n                 = 2'd0;
    r[0]              = '0;
    r[1]              = '0;
    do_begin          = 1'b0;
    mode_next         = mode;
    held_next         = held;
    line_next         = line;
    column_next       = column;
    start_line_next   = start_line;
    start_column_next = start_column;

    if (item.end_of_source) begin
      // flush what is held, then the end token; all state back to reset
      if (held.valid) begin
        r[n[0]] = mk(held.ch, held.kind, held.first, 1'b1, start_line, start_column);
        n = n + 2'd1;
      end else if (mode == sts_pkg::M_STR_OPEN) begin
        r[n[0]] = mk(8'd0, sts_pkg::KIND_STR, 1'b1, 1'b1, start_line, start_column);
        n = n + 2'd1;
      end
      r[n[0]] = mk(8'd0, sts_pkg::KIND_END, 1'b1, 1'b1, line, column);
      n = n + 2'd1;
      mode_next         = sts_pkg::M_IDLE;
      held_next         = '0;
      line_next         = POS_ONE;
      column_next       = POS_ONE;
      start_line_next   = POS_ONE;
      start_column_next = POS_ONE;
    end else begin
      unique case (mode)
        sts_pkg::M_NUM, sts_pkg::M_IDENT: begin
          r[n[0]] = mk(held.ch, held.kind, held.first, 1'b0, start_line, start_column);
          held_next.valid = 1'b0;
          if ((mode == sts_pkg::M_NUM) ? sts_pkg::is_digit(c) : sts_pkg::is_ident_more(c))
          begin
            n = n + 2'd1;
            held_next = '{ch: c, kind: held.kind, first: 1'b0, valid: 1'b1};
          end else begin
            r[n[0]].tok_last = 1'b1;
            n = n + 2'd1;
            do_begin = 1'b1;
          end
        end
        sts_pkg::M_STR_OPEN: begin
          if (c == sts_pkg::CH_QUOTE) begin
            r[n[0]] = mk(8'd0, sts_pkg::KIND_STR, 1'b1, 1'b1, start_line, start_column);
            n = n + 2'd1;
            mode_next = sts_pkg::M_IDLE;
          end else begin
            held_next = '{ch: c, kind: sts_pkg::KIND_STR, first: 1'b1, valid: 1'b1};
            mode_next = sts_pkg::M_STR;
          end
        end
        sts_pkg::M_STR: begin
          r[n[0]] = mk(held.ch, held.kind, held.first, c == sts_pkg::CH_QUOTE,
                       start_line, start_column);
          n = n + 2'd1;
          if (c == sts_pkg::CH_QUOTE) begin
            held_next.valid = 1'b0;
            mode_next = sts_pkg::M_IDLE;
          end else begin
            held_next = '{ch: c, kind: sts_pkg::KIND_STR, first: 1'b0, valid: 1'b1};
          end
        end
        sts_pkg::M_PAIR: begin
          held_next.valid = 1'b0;
          if (c == want) begin
            r[0] = mk(held.ch, held.kind, held.first, 1'b0, start_line, start_column);
            r[1] = mk(c, sts_pkg::KIND_OP, 1'b0, 1'b1, start_line, start_column);
            n = 2'd2;
            mode_next = sts_pkg::M_IDLE;
          end else begin
            r[n[0]] = mk(held.ch, held.kind, held.first, 1'b1, start_line, start_column);
            n = n + 2'd1;
            do_begin = 1'b1;
          end
        end
        sts_pkg::M_SLASH: begin
          held_next.valid = 1'b0;
          if (c == sts_pkg::CH_SLASH) begin
            mode_next = sts_pkg::M_LINE;
          end else if (c == sts_pkg::CH_STAR) begin
            mode_next = sts_pkg::M_BLOCK;
          end else begin
            r[n[0]] = mk(held.ch, held.kind, held.first, 1'b1, start_line, start_column);
            n = n + 2'd1;
            do_begin = 1'b1;
          end
        end
        sts_pkg::M_LINE: begin
          if (c == sts_pkg::CH_NEWLINE) begin
            mode_next = sts_pkg::M_IDLE;
          end
        end
        sts_pkg::M_BLOCK: begin
          if (c == sts_pkg::CH_STAR) begin
            mode_next = sts_pkg::M_BSTAR;
          end
        end
        sts_pkg::M_BSTAR: begin
          if (c == sts_pkg::CH_SLASH) begin
            mode_next = sts_pkg::M_IDLE;
          end else if (c != sts_pkg::CH_STAR) begin
            mode_next = sts_pkg::M_BLOCK;
          end
        end
        default: begin
          held_next.valid = 1'b0;
          do_begin = 1'b1;
        end
      endcase

      // open a new token at this byte, or emit it alone
      if (do_begin) begin
        mode_next = sts_pkg::M_IDLE;
        if (!sts_pkg::is_space(c)) begin
          if (sts_pkg::is_digit(c) || sts_pkg::is_ident_start(c) ||
              (c == sts_pkg::CH_QUOTE) || (c == sts_pkg::CH_SLASH) ||
              sts_pkg::is_pair_lead(c)) begin
            start_line_next   = line;
            start_column_next = column;
            if (sts_pkg::is_digit(c)) begin
              held_next = '{ch: c, kind: sts_pkg::KIND_NUM, first: 1'b1, valid: 1'b1};
              mode_next = sts_pkg::M_NUM;
            end else if (sts_pkg::is_ident_start(c)) begin
              held_next = '{ch: c, kind: sts_pkg::KIND_IDENT, first: 1'b1, valid: 1'b1};
              mode_next = sts_pkg::M_IDENT;
            end else if (c == sts_pkg::CH_QUOTE) begin
              held_next.valid = 1'b0;
              mode_next = sts_pkg::M_STR_OPEN;
            end else begin
              held_next = '{ch: c, kind: sts_pkg::KIND_OP, first: 1'b1, valid: 1'b1};
              mode_next = (c == sts_pkg::CH_SLASH) ? sts_pkg::M_SLASH : sts_pkg::M_PAIR;
            end
          end else begin
            r[n[0]] = mk(c, sts_pkg::single_kind(c), 1'b1, 1'b1, line, column);
            n = n + 2'd1;
          end
        end
      end

      // advance position, saturating
      if (c == sts_pkg::CH_NEWLINE) begin
        if (line != '1) begin
          line_next = line + POS_ONE;
        end
        column_next = POS_ONE;
      end else if (column != '1) begin
        column_next = column + POS_ONE;
      end
    end
  end

  assign res_count = n;
  assign res0 = r[0];
  assign res1 = r[1];

endmodule

// File: rtl/sts_resq.sv
module sts_resq (
  input  logic          clk,
  input  logic          rst,
  input  logic [1:0]    push_count,
  input  sts_pkg::out_t push0,
  input  sts_pkg::out_t push1,
  output logic          room,
  output logic          valid,
  input  logic          stall,
  output sts_pkg::out_t data
);

  localparam int unsigned PTR_BITS = $clog2(sts_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_BITS = $clog2(sts_pkg::QUEUE_DEPTH + 1);

  sts_pkg::out_t       mem [sts_pkg::QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                pop;

  assign valid = (count != '0);
  assign pop   = valid && !stall;
  assign data  = mem[rd_ptr];
  // two free entries are needed for the worst-case step
  assign room  = (count <= CNT_BITS'(sts_pkg::QUEUE_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      mem[wr_ptr] <= push0;
    end
    if (push_count == 2'd2) begin
      mem[wr_ptr + PTR_BITS'(1)] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_BITS'(push_count);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_BITS'(1);
      end
      count <= count + CNT_BITS'(push_count) - CNT_BITS'(pop);
    end
  end

endmodule

// File: rtl/source_token_scanner.sv
// Byte-stream scanner for C-like source text.
// src channel: one source byte per word (src_byte), or a word with
// end_of_source set that flushes the open token and emits the end token.
// tok channel: one token byte per word with its kind, first/last marks and
// the line/column where the token starts. Whitespace and comments make no
// words; one source byte makes zero, one or two token words.
// A word accepted on src waits in the input register until the result queue has
// room for a worst-case step; it is then scanned and its results enter the result
// queue, whose head is offered on tok.
// Throughput: one source byte per cycle while tok is free, through the scan stage
// between the input register and the four-entry result queue. A byte that
// makes two results always leaves the scanner idle, and a byte that makes none
// must come before the next such pair, so with tok free the queue holds at most
// two words and src never stalls.
// Reset clears the scan state to idle, line and column to 1, and empties
// the input register and the result queue. A stall on tok holds the head
// result; once the queue cannot take a worst-case step, src is stalled.
module source_token_scanner #(
  parameter int unsigned POSITION_BITS = sts_pkg::POSITION_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          src_valid,
  output logic          src_stall,
  input  sts_pkg::in_t  src_word,
  output logic          tok_valid,
  input  logic          tok_stall,
  output sts_pkg::out_t tok_word
);

  localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

  logic                     in_full;
  sts_pkg::in_t             in_reg;
  logic                     room;
  logic                     go;

  sts_pkg::mode_t           mode;
  sts_pkg::hold_t           held;
  logic [POSITION_BITS-1:0] line;
  logic [POSITION_BITS-1:0] column;
  logic [POSITION_BITS-1:0] start_line;
  logic [POSITION_BITS-1:0] start_column;

  sts_pkg::mode_t           mode_next;
  sts_pkg::hold_t           held_next;
  logic [POSITION_BITS-1:0] line_next;
  logic [POSITION_BITS-1:0] column_next;
  logic [POSITION_BITS-1:0] start_line_next;
  logic [POSITION_BITS-1:0] start_column_next;
  logic [1:0]               res_count;
  sts_pkg::out_t            res0;
  sts_pkg::out_t            res1;

  assign go        = in_full && room;
  assign src_stall = in_full && !room;

  always_ff @(posedge clk) begin
    if (src_valid && !src_stall) begin
      in_reg <= src_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (src_valid && !src_stall) begin
      in_full <= 1'b1;
    end else if (go) begin
      in_full <= 1'b0;
    end
  end

  sts_step #(
    .POSITION_BITS(POSITION_BITS)
  ) u_step (
    .item             (in_reg),
    .mode             (mode),
    .held             (held),
    .line             (line),
    .column           (column),
    .start_line       (start_line),
    .start_column     (start_column),
    .mode_next        (mode_next),
    .held_next        (held_next),
    .line_next        (line_next),
    .column_next      (column_next),
    .start_line_next  (start_line_next),
    .start_column_next(start_column_next),
    .res_count        (res_count),
    .res0             (res0),
    .res1             (res1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= sts_pkg::M_IDLE;
      held         <= '0;
      line         <= POS_ONE;
      column       <= POS_ONE;
      start_line   <= POS_ONE;
      start_column <= POS_ONE;
    end else if (go) begin
      mode         <= mode_next;
      held         <= held_next;
      line         <= line_next;
      column       <= column_next;
      start_line   <= start_line_next;
      start_column <= start_column_next;
    end
  end

  sts_resq u_resq (
    .clk       (clk),
    .rst       (rst),
    .push_count(go ? res_count : 2'd0),
    .push0     (res0),
    .push1     (res1),
    .room      (room),
    .valid     (tok_valid),
    .stall     (tok_stall),
    .data      (tok_word)
  );

endmodule

// File: rtl/sts_checker.sv
module sts_checker (
  input logic          clk,
  input logic          rst,
  input logic          src_valid,
  input logic          src_stall,
  input sts_pkg::in_t  src_word,
  input logic          tok_valid,
  input logic          tok_stall,
  input sts_pkg::out_t tok_word
);

  // hold a stalled source word
  a_src_hold: assert property (@(posedge clk) disable iff (rst)
    src_valid && src_stall |=> src_valid && $stable(src_word))
    else $error("stalled source word changed");

  // hold a stalled result word
  a_tok_hold: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok_stall |=> tok_valid && $stable(tok_word))
    else $error("stalled token word changed");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !tok_valid)
    else $error("token word offered after reset");

  a_end_form: assert property (@(posedge clk) disable iff (rst)
    tok_valid && (tok_word.tok_kind == sts_pkg::KIND_END) |->
      tok_word.tok_first && tok_word.tok_last && (tok_word.tok_byte == 8'd0))
    else $error("malformed end token");

  a_single_form: assert property (@(posedge clk) disable iff (rst)
    tok_valid && ((tok_word.tok_kind == sts_pkg::KIND_SYM) ||
                  (tok_word.tok_kind == sts_pkg::KIND_UNK)) |->
      tok_word.tok_first && tok_word.tok_last)
    else $error("one-byte token without both marks");

endmodule

bind source_token_scanner sts_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .src_valid(src_valid),
  .src_stall(src_stall),
  .src_word (src_word),
  .tok_valid(tok_valid),
  .tok_stall(tok_stall),
  .tok_word (tok_word)
);

// File: verif/source_token_checker.sv
`timescale 1ns / 1ps
module source_token_checker #(
  parameter int unsigned POSITION_BITS = sts_pkg::POSITION_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          src_valid,
  input  logic          src_stall,
  input  sts_pkg::in_t  src_word,
  input  logic          tok_valid,
  input  logic          tok_stall,
  input  sts_pkg::out_t tok_word,
  output int            failures,
  output int            pending
);

  localparam logic [63:0] POS_MAX = (64'd1 << POSITION_BITS) - 64'd1;

  sts_pkg::mode_t lex_mode;
  logic [7:0]     held_ch;
  sts_pkg::kind_t held_kind;
  logic           held_open;
  logic           held_live;
  logic [63:0]    cur_line;
  logic [63:0]    cur_col;
  logic [63:0]    open_line;
  logic [63:0]    open_col;

  sts_pkg::out_t expected_tokens[$];
  int            fail_count = 0;
  int            waiting_count = 0;

  assign failures = fail_count;
  assign pending  = waiting_count;

  function automatic logic char_digit(input logic [7:0] ch);
    return (ch >= "0") && (ch <= "9");
  endfunction

  function automatic logic char_word_start(input logic [7:0] ch);
    return ((ch >= "a") && (ch <= "z")) || ((ch >= "A") && (ch <= "Z")) ||
           (ch == sts_pkg::CH_UNDERSCORE);
  endfunction

  function automatic logic char_blank(input logic [7:0] ch);
    return (ch == 8'h20) || ((ch >= 8'h09) && (ch <= 8'h0D));
  endfunction

  function automatic logic char_pair_lead(input logic [7:0] ch);
    return (ch == "<") || (ch == ">") || (ch == "!") || (ch == sts_pkg::CH_AMP) ||
           (ch == sts_pkg::CH_BAR);
  endfunction

  function automatic void clear_scan();
    lex_mode  = sts_pkg::M_IDLE;
    held_ch   = 8'h00;
    held_kind = sts_pkg::KIND_NUM;
    held_open = 1'b0;
    held_live = 1'b0;
    cur_line  = 64'd1;
    cur_col   = 64'd1;
    open_line = 64'd1;
    open_col  = 64'd1;
  endfunction

  function automatic void push_token(input logic [7:0] ch, input sts_pkg::kind_t kind,
                                     input logic opens, input logic closes,
                                     input logic [63:0] ln, input logic [63:0] cl);
    sts_pkg::out_t w;
    w.tok_byte   = ch;
    w.tok_kind   = kind;
    w.tok_first  = opens;
    w.tok_last   = closes;
    w.tok_line   = ln[15:0];
    w.tok_column = cl[15:0];
    expected_tokens.insert(expected_tokens.size(), w);
  endfunction

  function automatic void flush_held(input logic closes);
    held_live = 1'b0;
    push_token(held_ch, held_kind, held_open, closes, open_line, open_col);
  endfunction

  function automatic void hold_char(input logic [7:0] ch, input sts_pkg::kind_t kind,
                                    input logic opens);
    held_ch   = ch;
    held_kind = kind;
    held_open = opens;
    held_live = 1'b1;
  endfunction

  // Byte seen with no token open; ln/cl is its own position.
  function automatic void open_token(input logic [7:0] ch, input logic [63:0] ln,
                                     input logic [63:0] cl);
    lex_mode = sts_pkg::M_IDLE;
    if (char_blank(ch)) begin
      return;
    end
    if (char_digit(ch) || char_word_start(ch) || ch == sts_pkg::CH_QUOTE ||
        ch == sts_pkg::CH_SLASH || char_pair_lead(ch)) begin
      open_line = ln;
      open_col  = cl;
      if (char_digit(ch)) begin
        hold_char(ch, sts_pkg::KIND_NUM, 1'b1);
        lex_mode = sts_pkg::M_NUM;
      end else if (char_word_start(ch)) begin
        hold_char(ch, sts_pkg::KIND_IDENT, 1'b1);
        lex_mode = sts_pkg::M_IDENT;
      end else if (ch == sts_pkg::CH_QUOTE) begin
        held_live = 1'b0;
        lex_mode  = sts_pkg::M_STR_OPEN;
      end else if (ch == sts_pkg::CH_SLASH) begin
        hold_char(ch, sts_pkg::KIND_OP, 1'b1);
        lex_mode = sts_pkg::M_SLASH;
      end else begin
        hold_char(ch, sts_pkg::KIND_OP, 1'b1);
        lex_mode = sts_pkg::M_PAIR;
      end
    end else if (ch == "+" || ch == "-" || ch == sts_pkg::CH_STAR ||
                 ch == sts_pkg::CH_EQUAL) begin
      push_token(ch, sts_pkg::KIND_OP, 1'b1, 1'b1, ln, cl);
    end else if (ch == "(" || ch == ")" || ch == "{" || ch == "}" || ch == ";" ||
                 ch == ",") begin
      push_token(ch, sts_pkg::KIND_SYM, 1'b1, 1'b1, ln, cl);
    end else begin
      push_token(ch, sts_pkg::KIND_UNK, 1'b1, 1'b1, ln, cl);
    end
  endfunction

  function automatic void predict_word(input sts_pkg::in_t w);
    logic [7:0]  ch;
    logic [7:0]  partner;
    logic [63:0] ln;
    logic [63:0] cl;
    ch = w.src_byte;
    ln = cur_line;
    cl = cur_col;
    if (w.end_of_source) begin
      if (held_live) begin
        flush_held(1'b1);
      end else if (lex_mode == sts_pkg::M_STR_OPEN) begin
        push_token(8'h00, sts_pkg::KIND_STR, 1'b1, 1'b1, open_line, open_col);
      end
      push_token(8'h00, sts_pkg::KIND_END, 1'b1, 1'b1, cur_line, cur_col);
      clear_scan();
      return;
    end
    case (lex_mode)
      sts_pkg::M_NUM: begin
        if (char_digit(ch)) begin
          flush_held(1'b0);
          hold_char(ch, sts_pkg::KIND_NUM, 1'b0);
        end else begin
          flush_held(1'b1);
          open_token(ch, ln, cl);
        end
      end
      sts_pkg::M_IDENT: begin
        if (char_word_start(ch) || char_digit(ch)) begin
          flush_held(1'b0);
          hold_char(ch, sts_pkg::KIND_IDENT, 1'b0);
        end else begin
          flush_held(1'b1);
          open_token(ch, ln, cl);
        end
      end
      sts_pkg::M_STR_OPEN: begin
        if (ch == sts_pkg::CH_QUOTE) begin
          push_token(8'h00, sts_pkg::KIND_STR, 1'b1, 1'b1, open_line, open_col);
          lex_mode = sts_pkg::M_IDLE;
        end else begin
          hold_char(ch, sts_pkg::KIND_STR, 1'b1);
          lex_mode = sts_pkg::M_STR;
        end
      end
      sts_pkg::M_STR: begin
        if (ch == sts_pkg::CH_QUOTE) begin
          flush_held(1'b1);
          lex_mode = sts_pkg::M_IDLE;
        end else begin
          flush_held(1'b0);
          hold_char(ch, sts_pkg::KIND_STR, 1'b0);
        end
      end
      sts_pkg::M_PAIR: begin
        partner = (held_ch == sts_pkg::CH_AMP || held_ch == sts_pkg::CH_BAR) ?
                  held_ch : sts_pkg::CH_EQUAL;
        if (ch == partner) begin
          flush_held(1'b0);
          push_token(ch, sts_pkg::KIND_OP, 1'b0, 1'b1, open_line, open_col);
          lex_mode = sts_pkg::M_IDLE;
        end else begin
          flush_held(1'b1);
          open_token(ch, ln, cl);
        end
      end
      sts_pkg::M_SLASH: begin
        if (ch == sts_pkg::CH_SLASH) begin
          held_live = 1'b0;
          lex_mode  = sts_pkg::M_LINE;
        end else if (ch == sts_pkg::CH_STAR) begin
          held_live = 1'b0;
          lex_mode  = sts_pkg::M_BLOCK;
        end else begin
          flush_held(1'b1);
          open_token(ch, ln, cl);
        end
      end
      sts_pkg::M_LINE: begin
        if (ch == sts_pkg::CH_NEWLINE) lex_mode = sts_pkg::M_IDLE;
      end
      sts_pkg::M_BLOCK: begin
        if (ch == sts_pkg::CH_STAR) lex_mode = sts_pkg::M_BSTAR;
      end
      sts_pkg::M_BSTAR: begin
        if (ch == sts_pkg::CH_SLASH) lex_mode = sts_pkg::M_IDLE;
        else if (ch != sts_pkg::CH_STAR) lex_mode = sts_pkg::M_BLOCK;
      end
      default: begin
        held_live = 1'b0;
        open_token(ch, ln, cl);
      end
    endcase
    // advance position, saturating
    if (ch == sts_pkg::CH_NEWLINE) begin
      if (cur_line < POS_MAX) cur_line = cur_line + 64'd1;
      cur_col = 64'd1;
    end else if (cur_col < POS_MAX) begin
      cur_col = cur_col + 64'd1;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: %s: got %0h, want %0h", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin : watch_words
    sts_pkg::out_t want;
    if (rst) begin
      clear_scan();
      expected_tokens.delete();
    end else begin
      if (src_valid && !src_stall) predict_word(src_word);
      if (tok_valid && !tok_stall) begin
        if (expected_tokens.size() == 0) begin
          report_mismatch("token word with nothing expected", 64'(tok_word), 64'd0);
        end else begin
          want = expected_tokens.pop_front();
          if (tok_word.tok_byte !== want.tok_byte)
            report_mismatch("tok_byte", 64'(tok_word.tok_byte), 64'(want.tok_byte));
          if (tok_word.tok_kind !== want.tok_kind)
            report_mismatch("tok_kind", 64'(tok_word.tok_kind), 64'(want.tok_kind));
          if (tok_word.tok_first !== want.tok_first)
            report_mismatch("tok_first", 64'(tok_word.tok_first), 64'(want.tok_first));
          if (tok_word.tok_last !== want.tok_last)
            report_mismatch("tok_last", 64'(tok_word.tok_last), 64'(want.tok_last));
          if (tok_word.tok_line !== want.tok_line)
            report_mismatch("tok_line", 64'(tok_word.tok_line), 64'(want.tok_line));
          if (tok_word.tok_column !== want.tok_column)
            report_mismatch("tok_column", 64'(tok_word.tok_column),
                            64'(want.tok_column));
        end
      end
    end
    waiting_count <= expected_tokens.size();
  end

endmodule

// File: verif/tb_source_token_scanner.sv
`timescale 1ns / 1ps
module tb_source_token_scanner;

  localparam int RANDOM_WORDS = 1750;
  localparam int PHASES = 4;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          src_valid = 1'b0;
  logic          src_stall;
  sts_pkg::in_t  src_word = '0;
  logic          tok_valid;
  logic          tok_stall = 1'b0;
  sts_pkg::out_t tok_word;

  int failures;
  int pending;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int words_sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  source_token_scanner DUT (
    .clk      (clk),
    .rst      (rst),
    .src_valid(src_valid),
    .src_stall(src_stall),
    .src_word (src_word),
    .tok_valid(tok_valid),
    .tok_stall(tok_stall),
    .tok_word (tok_word)
  );

  source_token_checker CHK (
    .clk      (clk),
    .rst      (rst),
    .src_valid(src_valid),
    .src_stall(src_stall),
    .src_word (src_word),
    .tok_valid(tok_valid),
    .tok_stall(tok_stall),
    .tok_word (tok_word),
    .failures (failures),
    .pending  (pending)
  );

  always @(posedge clk) begin
    tok_stall <= (sink_stall_pct > 0) && ($urandom_range(99) < sink_stall_pct);
  end

  task automatic send_word(input logic [7:0] ch, input logic eos);
    sts_pkg::in_t w;
    while ((src_idle_pct > 0) && ($urandom_range(99) < src_idle_pct)) begin
      src_valid <= 1'b0;
      @(posedge clk);
    end
    w.src_byte      = ch;
    w.end_of_source = eos;
    src_valid <= 1'b1;
    src_word  <= w;
    @(posedge clk);
    while (src_stall) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  task automatic end_source();
    send_word(8'($urandom_range(255)), 1'b1);
  endtask

  // Hold the sender off until every expected token word has come back.
  task automatic drain_tokens();
    src_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] word_char(input logic lead);
    case ($urandom_range(lead ? 2 : 3))
      0: return 8'("a" + $urandom_range(25));
      1: return 8'("A" + $urandom_range(25));
      2: return sts_pkg::CH_UNDERSCORE;
      default: return 8'("0" + $urandom_range(9));
    endcase
  endfunction

  function automatic logic [7:0] blank_char();
    int pick;
    pick = $urandom_range(6);
    return (pick > 4) ? 8'h20 : 8'(8'h09 + pick);
  endfunction

  task automatic send_fragment();
    string      singles = "+-*=(){};,/";
    string      leads = "<>!&|";
    string      comment_pool = "**//x \n";
    logic [7:0] ch;
    case ($urandom_range(11))
      0: begin
        repeat ($urandom_range(6, 1)) send_word(8'("0" + $urandom_range(9)), 1'b0);
      end
      1: begin
        send_word(word_char(1'b1), 1'b0);
        repeat ($urandom_range(6)) send_word(word_char(1'b0), 1'b0);
      end
      2: begin
        send_word(sts_pkg::CH_QUOTE, 1'b0);
        repeat ($urandom_range(5)) begin
          do ch = ($urandom_range(1) != 0) ? word_char(1'b0) : 8'($urandom_range(255));
          while (ch == sts_pkg::CH_QUOTE);
          send_word(ch, 1'b0);
        end
        // leave a few strings open
        if ($urandom_range(9) != 0) send_word(sts_pkg::CH_QUOTE, 1'b0);
      end
      3: begin
        ch = leads[$urandom_range(leads.len() - 1)];
        send_word(ch, 1'b0);
        case ($urandom_range(2))
          0: send_word(sts_pkg::CH_EQUAL, 1'b0);
          1: send_word(ch, 1'b0);
          default: ;
        endcase
      end
      4: send_word(singles[$urandom_range(singles.len() - 1)], 1'b0);
      5: begin
        send_text("//");
        repeat ($urandom_range(8)) begin
          do ch = 8'($urandom_range(255));
          while (ch == sts_pkg::CH_NEWLINE);
          send_word(ch, 1'b0);
        end
        if ($urandom_range(4) != 0) send_word(sts_pkg::CH_NEWLINE, 1'b0);
      end
      6: begin
        send_text("/*");
        repeat ($urandom_range(8)) begin
          ch = ($urandom_range(3) != 0) ? comment_pool[$urandom_range(comment_pool.len() - 1)]
                                        : 8'($urandom_range(255));
          send_word(ch, 1'b0);
        end
        if ($urandom_range(9) != 0) send_text("*/");
      end
      7, 8, 9: begin
        repeat ($urandom_range(3, 1)) send_word(blank_char(), 1'b0);
      end
      default: send_word(8'($urandom_range(255)), 1'b0);
    endcase
  endtask

  task automatic send_random_source();
    repeat ($urandom_range(40, 1)) send_fragment();
    end_source();
  endtask

  initial begin : stimulus
    int phase_goal;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // identifier, paired op, number, symbol, line comment, open block comment
    send_text("ab<=7;//\n/*");
    end_source();
    // empty string, block comment, && pair, lone | then unknown bytes at both extremes
    send_text("\"\"/*x*/&&|");
    send_word(8'hFF, 1'b0);
    send_word(8'h00, 1'b0);
    end_source();
    // lone slash, then string left open at end of source
    send_text("/\"q");
    end_source();
    // empty string left open
    send_text("\"");
    end_source();

    for (int p = 0; p < PHASES; p++) begin
      drain_tokens();
      case (p)
        0: begin
          src_idle_pct = 0;
          sink_stall_pct <= 0;
        end
        1: begin
          src_idle_pct = 62;
          sink_stall_pct <= 0;
        end
        2: begin
          src_idle_pct = 0;
          sink_stall_pct <= 62;
        end
        default: begin
          src_idle_pct = 13;
          sink_stall_pct <= 13;
        end
      endcase
      phase_goal = words_sent + RANDOM_WORDS / PHASES;
      while (words_sent < phase_goal) send_random_source();
    end

    drain_tokens();
    repeat (10) @(posedge clk);
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: filelist.f
rtl/sts_pkg.sv
rtl/sts_step.sv
rtl/sts_resq.sv
rtl/source_token_scanner.sv
rtl/sts_checker.sv
verif/source_token_checker.sv
verif/tb_source_token_scanner.sv
